>>> rtl/tema_pkg.sv
// Shared types, constants and the divider step function for the triangle element assembler.
`timescale 1ns / 1ps
`default_nettype none
package tema_pkg;

  localparam int QDEPTH = 4;
  localparam int DIV_STAGES = 32;
  localparam logic [3:0] LAST_PAIR = 4'd8;

  // The reciprocal of 3 scaled by 2^49, split into 24-bit halves, for the mass division.
  localparam logic [23:0] MASS_RCP_LO = 24'hAAAAAB;
  localparam logic [23:0] MASS_RCP_HI = 24'hAAAAAA;

  typedef struct packed {
    logic [2:0][15:0] vid;
    logic [2:0][24:0] ex;
    logic [2:0][24:0] ey;
    logic [49:0]      acr;
    logic             degen;
  } tri_t;

  typedef struct packed {
    logic        vld;
    logic [15:0] row;
    logic [15:0] col;
    logic        neg;
    logic        ovf;
    logic        degen;
    logic        last;
    logic [49:0] den;
    logic [49:0] rem;
    logic [31:0] nbits;
    logic [31:0] q;
    logic [45:0] mq;
  } dstage_t;

  typedef struct packed {
    logic [15:0] row_vertex;
    logic [15:0] col_vertex;
    logic [31:0] stiffness;
    logic [45:0] mass;
    logic        degenerate;
    logic        last;
  } res_t;

  // One quotient bit of the stiffness division.
  function automatic dstage_t div_step(dstage_t s);
    logic [50:0] t;
    dstage_t     o;
    o = s;
    t = {s.rem, s.nbits[31]};
    if (t >= {1'b0, s.den}) begin
      o.rem = 50'(t - {1'b0, s.den});
      o.q   = {s.q[30:0], 1'b1};
    end else begin
      o.rem = t[49:0];
      o.q   = {s.q[30:0], 1'b0};
    end
    o.nbits = {s.nbits[30:0], 1'b0};
    return o;
  endfunction

endpackage
`default_nettype wire

>>> rtl/triangle_element_matrix_assembler_unit.sv
// Top level of the triangle element matrix assembler.
// Throughput: nine result transactions per triangle, one per cycle while the two-entry result buffer has room,
// set by the single issue port of the pair sequencer feeding the 32-stage divider pipeline.
// Reset clears all valid flags, counters and queue pointers; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module triangle_element_matrix_assembler_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [15:0]        in_vertex_a,
  input  wire logic [15:0]        in_vertex_b,
  input  wire logic [15:0]        in_vertex_c,
  input  wire logic signed [23:0] in_ax,
  input  wire logic signed [23:0] in_ay,
  input  wire logic signed [23:0] in_bx,
  input  wire logic signed [23:0] in_by_coord,
  input  wire logic signed [23:0] in_cx,
  input  wire logic signed [23:0] in_cy,
  output logic                    empty,
  input  wire logic               pop,
  output logic [15:0]             out_row_vertex,
  output logic [15:0]             out_col_vertex,
  output logic signed [31:0]      out_stiffness,
  output logic [45:0]             out_mass,
  output logic                    out_degenerate,
  output logic                    out_last
);
  import tema_pkg::*;

  logic room, q_push, q_pop, head_vld;
  tri_t tri_in, head;
  res_t res;

  assign full = ~room;

  tema_front u_front (
    .clk, .rst_n, .room,
    .in_push(push),
    .in_vertex_a, .in_vertex_b, .in_vertex_c,
    .in_ax, .in_ay, .in_bx, .in_by_coord, .in_cx, .in_cy,
    .push(q_push),
    .tri_out(tri_in)
  );

  tema_queue u_queue (
    .clk, .rst_n,
    .push(q_push),
    .din(tri_in),
    .pop(q_pop),
    .dout(head),
    .head_vld,
    .room
  );

  tema_back u_back (
    .clk, .rst_n,
    .head,
    .head_vld,
    .pop(q_pop),
    .out_pop(pop),
    .out_empty(empty),
    .res
  );

  assign out_row_vertex = res.row_vertex;
  assign out_col_vertex = res.col_vertex;
  assign out_stiffness = res.stiffness;
  assign out_mass = res.mass;
  assign out_degenerate = res.degenerate;
  assign out_last = res.last;
endmodule
`default_nettype wire

>>> rtl/tema_front.sv
// Front end: accepts triangles, forms edges and the doubled area, and classifies degenerate ones.
`timescale 1ns / 1ps
`default_nettype none
module tema_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               room,
  input  wire logic               in_push,
  input  wire logic [15:0]        in_vertex_a,
  input  wire logic [15:0]        in_vertex_b,
  input  wire logic [15:0]        in_vertex_c,
  input  wire logic signed [23:0] in_ax,
  input  wire logic signed [23:0] in_ay,
  input  wire logic signed [23:0] in_bx,
  input  wire logic signed [23:0] in_by_coord,
  input  wire logic signed [23:0] in_cx,
  input  wire logic signed [23:0] in_cy,
  output logic                    push,
  output tema_pkg::tri_t          tri_out
);
  import tema_pkg::*;

  logic               e_vld_r, p_vld_r, t_vld_r;
  tri_t               e_r, p_r, t_r;
  logic signed [49:0] m0_r, m1_r;
  logic signed [50:0] area2;

  assign area2 = {m1_r[49], m1_r} - {m0_r[49], m0_r};
  assign push = room && t_vld_r;
  assign tri_out = t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
      p_vld_r <= 1'b0;
      t_vld_r <= 1'b0;
    end else if (room) begin
      e_vld_r <= in_push;
      p_vld_r <= e_vld_r;
      t_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (room) begin
      e_r.vid   <= {in_vertex_c, in_vertex_b, in_vertex_a};
      e_r.ex[0] <= {in_bx[23], in_bx} - {in_ax[23], in_ax};
      e_r.ey[0] <= {in_by_coord[23], in_by_coord} - {in_ay[23], in_ay};
      e_r.ex[1] <= {in_cx[23], in_cx} - {in_bx[23], in_bx};
      e_r.ey[1] <= {in_cy[23], in_cy} - {in_by_coord[23], in_by_coord};
      e_r.ex[2] <= {in_ax[23], in_ax} - {in_cx[23], in_cx};
      e_r.ey[2] <= {in_ay[23], in_ay} - {in_cy[23], in_cy};
      e_r.acr   <= '0;
      e_r.degen <= 1'b0;
      p_r  <= e_r;
      m0_r <= $signed(e_r.ex[0]) * $signed(e_r.ey[2]);
      m1_r <= $signed(e_r.ey[0]) * $signed(e_r.ex[2]);
      t_r.vid   <= p_r.vid;
      t_r.ex    <= p_r.ex;
      t_r.ey    <= p_r.ey;
      t_r.acr   <= area2[50] ? 50'(-area2) : area2[49:0];
      t_r.degen <= (area2 == 51'sd0);
    end
  end
endmodule
`default_nettype wire

>>> rtl/tema_queue.sv
// Short queue of classified triangles between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module tema_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  tema_pkg::tri_t din,
  input  wire logic      pop,
  output tema_pkg::tri_t dout,
  output logic           head_vld,
  output logic           room
);
  import tema_pkg::*;

  tri_t       mem_r [QDEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign dout = mem_r[rp_r];
  assign head_vld = (cnt_r != 3'd0);
  assign room = (cnt_r < 3'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 2'd1;
      end
      if (pop) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + {2'b0, push} - {2'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> rtl/tema_back.sv
// Back end: walks the nine vertex pairs, computes dot products and mass terms, divides and buffers results.
`timescale 1ns / 1ps
`default_nettype none
module tema_back (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  tema_pkg::tri_t head,
  input  wire logic      head_vld,
  output logic           pop,
  input  wire logic      out_pop,
  output logic           out_empty,
  output tema_pkg::res_t res
);
  import tema_pkg::*;

  typedef struct packed {
    logic        vld;
    logic [15:0] row;
    logic [15:0] col;
    logic        diag;
    logic        degen;
    logic        last;
    logic [49:0] acr;
  } meta_t;

  logic        back_en;
  logic [3:0]  pc_r;
  logic [1:0]  i_sel, j_sel, a_sel, b_sel;

  meta_t              is_r, pr_r, dt_r;
  logic [24:0]        exa_r, eya_r, exb_r, eyb_r;
  logic signed [49:0] pxx_r, pyy_r;
  logic [50:0]        dot_r;
  logic [47:0]        mx_r;
  logic [47:0]        mll_r, mlh_r, mhl_r, mhh_r;
  logic [48:0]        mmid;
  logic [95:0]        macc;
  logic [45:0]        mq_r;
  dstage_t            st_r [DIV_STAGES + 1];
  dstage_t            sl [DIV_STAGES];
  dstage_t            st0;
  logic [49:0]        mabs;
  logic [49:0]        den;

  res_t       ores_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;
  logic       opush, opop;
  res_t       fin;
  logic [32:0] mag;

  assign back_en = (ocnt_r < 2'd2);
  assign pop = back_en && head_vld && (pc_r == LAST_PAIR);

  always_comb begin
    case (pc_r)
      4'd0: begin i_sel = 2'd0; j_sel = 2'd0; end
      4'd1: begin i_sel = 2'd0; j_sel = 2'd1; end
      4'd2: begin i_sel = 2'd0; j_sel = 2'd2; end
      4'd3: begin i_sel = 2'd1; j_sel = 2'd0; end
      4'd4: begin i_sel = 2'd1; j_sel = 2'd1; end
      4'd5: begin i_sel = 2'd1; j_sel = 2'd2; end
      4'd6: begin i_sel = 2'd2; j_sel = 2'd0; end
      4'd7: begin i_sel = 2'd2; j_sel = 2'd1; end
      4'd8: begin i_sel = 2'd2; j_sel = 2'd2; end
      default: begin i_sel = 2'd0; j_sel = 2'd0; end
    endcase
    a_sel = (i_sel == 2'd2) ? 2'd0 : i_sel + 2'd1;
    b_sel = (j_sel == 2'd2) ? 2'd0 : j_sel + 2'd1;
  end

  always_comb begin
    mmid = {1'b0, mlh_r} + {1'b0, mhl_r};
    macc = {48'b0, mll_r} + {23'b0, mmid, 24'b0} + {mhh_r, 48'b0};
  end

  always_comb begin
    mabs = dot_r[50] ? 50'(-dot_r) : dot_r[49:0];
    den  = {dt_r.acr[48:0], 1'b0};
    st0.vld   = dt_r.vld;
    st0.row   = dt_r.row;
    st0.col   = dt_r.col;
    st0.neg   = dot_r[50];
    st0.ovf   = ({16'b0, mabs} >= {den, 16'b0});
    st0.degen = dt_r.degen;
    st0.last  = dt_r.last;
    st0.den   = den;
    st0.rem   = {16'b0, mabs[49:16]};
    st0.nbits = {mabs[15:0], 16'b0};
    st0.q     = '0;
    st0.mq    = mq_r;
  end

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      sl[k] = div_step(st_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      is_r.vld <= 1'b0;
      pr_r.vld <= 1'b0;
      dt_r.vld <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) begin
        st_r[k].vld <= 1'b0;
      end
    end else if (back_en) begin
      if (head_vld) begin
        pc_r <= (pc_r == LAST_PAIR) ? 4'd0 : pc_r + 4'd1;
      end
      is_r.vld <= head_vld;
      pr_r.vld <= is_r.vld;
      dt_r.vld <= pr_r.vld;
      st_r[0].vld <= dt_r.vld;
      for (int k = 0; k < DIV_STAGES; k++) begin
        st_r[k + 1].vld <= st_r[k].vld;
      end
    end
    if (back_en) begin
      is_r.row   <= head.vid[i_sel];
      is_r.col   <= head.vid[j_sel];
      is_r.diag  <= (i_sel == j_sel);
      is_r.degen <= head.degen;
      is_r.last  <= (pc_r == LAST_PAIR);
      is_r.acr   <= head.acr;
      mx_r  <= (i_sel == j_sel) ? head.acr[49:2] : {1'b0, head.acr[49:3]};
      exa_r <= head.ex[a_sel];
      eya_r <= head.ey[a_sel];
      exb_r <= head.ex[b_sel];
      eyb_r <= head.ey[b_sel];
      pr_r.row   <= is_r.row;
      pr_r.col   <= is_r.col;
      pr_r.diag  <= is_r.diag;
      pr_r.degen <= is_r.degen;
      pr_r.last  <= is_r.last;
      pr_r.acr   <= is_r.acr;
      pxx_r <= $signed(exa_r) * $signed(exb_r);
      pyy_r <= $signed(eya_r) * $signed(eyb_r);
      mll_r <= mx_r[23:0] * MASS_RCP_LO;
      mlh_r <= mx_r[23:0] * MASS_RCP_HI;
      mhl_r <= mx_r[47:24] * MASS_RCP_LO;
      mhh_r <= mx_r[47:24] * MASS_RCP_HI;
      dt_r.row   <= pr_r.row;
      dt_r.col   <= pr_r.col;
      dt_r.diag  <= pr_r.diag;
      dt_r.degen <= pr_r.degen;
      dt_r.last  <= pr_r.last;
      dt_r.acr   <= pr_r.acr;
      dot_r <= {pxx_r[49], pxx_r} + {pyy_r[49], pyy_r};
      mq_r  <= macc[94:49];
      st_r[0].row   <= st0.row;
      st_r[0].col   <= st0.col;
      st_r[0].neg   <= st0.neg;
      st_r[0].ovf   <= st0.ovf;
      st_r[0].degen <= st0.degen;
      st_r[0].last  <= st0.last;
      st_r[0].den   <= st0.den;
      st_r[0].rem   <= st0.rem;
      st_r[0].nbits <= st0.nbits;
      st_r[0].q     <= st0.q;
      st_r[0].mq    <= st0.mq;
      for (int k = 0; k < DIV_STAGES; k++) begin
        st_r[k + 1].row   <= sl[k].row;
        st_r[k + 1].col   <= sl[k].col;
        st_r[k + 1].neg   <= sl[k].neg;
        st_r[k + 1].ovf   <= sl[k].ovf;
        st_r[k + 1].degen <= sl[k].degen;
        st_r[k + 1].last  <= sl[k].last;
        st_r[k + 1].den   <= sl[k].den;
        st_r[k + 1].rem   <= sl[k].rem;
        st_r[k + 1].nbits <= sl[k].nbits;
        st_r[k + 1].q     <= sl[k].q;
        st_r[k + 1].mq    <= sl[k].mq;
      end
    end
  end

  always_comb begin
    mag = st_r[DIV_STAGES].ovf ? 33'h080000001 : {1'b0, st_r[DIV_STAGES].q};
    fin.row_vertex = st_r[DIV_STAGES].row;
    fin.col_vertex = st_r[DIV_STAGES].col;
    if (st_r[DIV_STAGES].degen) begin
      fin.stiffness = '0;
    end else if (!st_r[DIV_STAGES].neg) begin
      fin.stiffness = (mag > 33'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    end else begin
      fin.stiffness = (mag > 33'h080000000) ? 32'h80000000 : 32'(33'd0 - mag);
    end
    fin.mass = st_r[DIV_STAGES].mq;
    fin.degenerate = st_r[DIV_STAGES].degen;
    fin.last = st_r[DIV_STAGES].last;
  end

  assign opush = back_en && st_r[DIV_STAGES].vld;
  assign opop = out_pop && (ocnt_r != 2'd0);
  assign out_empty = (ocnt_r == 2'd0);
  assign res = ores_r[orp_r];

  always_ff @(posedge clk) begin
    if (opush) begin
      ores_r[owp_r] <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= '0;
    end else begin
      if (opush) begin
        owp_r <= ~owp_r;
      end
      if (opop) begin
        orp_r <= ~orp_r;
      end
      ocnt_r <= ocnt_r + {1'b0, opush} - {1'b0, opop};
    end
  end
endmodule
`default_nettype wire
